// File: sv/text_console_putchar_defines.svh
// Assertion macros used by the text console RTL.
`ifndef TEXT_CONSOLE_PUTCHAR_DEFINES_SVH
`define TEXT_CONSOLE_PUTCHAR_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define TCP_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a trigger in one cycle is followed by a condition in the next.
`define TCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tcp_pkg.sv
// Shared constants, payload types and address helpers of the text console.
package tcp_pkg;

   localparam int WIDTH      = 80;
   localparam int HEIGHT     = 25;
   localparam int CELL_COUNT = WIDTH * HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int POS_W   = 11;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int CELL_W  = CHAR_W + COLOR_W;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } tcp_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  cell_char;
      logic [COLOR_W-1:0] cell_color;
      logic [ROW_W-1:0]   cursor_row;
      logic [COL_W-1:0]   cursor_col;
      logic [POS_W-1:0]   cursor_pos;
      logic               scrolled;
   } tcp_rsp_type;

   // Map a screen row onto its stored row; the store rotates by one row per scroll.
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] top);
      logic [ROW_W:0] sum;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= (ROW_W+1)'(HEIGHT))
         sum = sum - (ROW_W+1)'(HEIGHT);
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(WIDTH) + ADDR_W'(col);
   endfunction

   function automatic logic [POS_W-1:0] linear_pos(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return POS_W'(row) * POS_W'(WIDTH) + POS_W'(col);
   endfunction

endpackage

// File: sv/tcp_req_if.sv
// Request channel of the text console: valid, ready and one command.
interface tcp_req_if;
   import tcp_pkg::*;

   logic        valid;
   logic        ready;
   tcp_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/tcp_rsp_if.sv
// Response channel of the text console: valid, ready and one result.
interface tcp_rsp_if;
   import tcp_pkg::*;

   logic        valid;
   logic        ready;
   tcp_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/text_console_putchar.sv
// Text console engine: character store, cursor, scrolling and cell read-back.
//
//   channel   direction  handshake                   carries
//   req_chan  in         valid/ready                 operation, char_code, read_row, read_col
//   rsp_chan  out        valid/ready                 cell, cursor row/col/pos, scrolled
//   csr_*     in         write enable, no stall      text_color
//
// Put: the cell write (none for a newline) and cursor update land at the edge that accepts it.
// Read: the cell RAM has a registered read port, so the cell reaches the output register through ST_READ.
// Scrolling put: the store rotates by one row and the freed
// row is rewritten one cell per cycle through the single RAM write port.
// After reset a clearing pass blanks the RAM; no request is taken until it ends.
// A new request waits until the output register is empty or being drained.
`include "text_console_putchar_defines.svh"

module text_console_putchar (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [tcp_pkg::COLOR_W-1:0]  csr_write_data,
   tcp_req_if.sink                      req_chan,
   tcp_rsp_if.source                    rsp_chan
);
   import tcp_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_FILL  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [COL_W-1:0]   fill_col_ff, fill_col_in;
   logic [ADDR_W-1:0]  fill_base_ff, fill_base_in;
   logic [ROW_W-1:0]   top_ff, top_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               rd_oob_ff, rd_oob_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tcp_rsp_type        rsp_data_ff, rsp_data_in;

   logic               req_fire;
   logic               is_put;
   logic               is_newline;
   logic [COL_W:0]     col_inc;
   logic [ROW_W:0]     row_inc;
   logic               wrap;
   logic               scroll;
   logic [ROW_W-1:0]   next_row;
   logic [COL_W-1:0]   next_col;
   logic               rd_oob;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [CELL_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [CELL_W-1:0]  ram_rd_data;

   tcp_ram #(
      .DATA_W (CELL_W),
      .DEPTH  (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Cursor advance for a put
   assign is_put     = (req_chan.payload.operation == OP_PUT);
   assign is_newline = (req_chan.payload.char_code == NEWLINE_CODE);
   assign col_inc    = {1'b0, cur_col_ff} + (COL_W+1)'(1);
   assign row_inc    = {1'b0, cur_row_ff} + (ROW_W+1)'(1);
   assign wrap       = is_newline || (col_inc >= (COL_W+1)'(WIDTH));
   assign scroll     = wrap && (row_inc >= (ROW_W+1)'(HEIGHT));
   assign next_col   = wrap ? '0 : col_inc[COL_W-1:0];
   assign next_row   = !wrap ? cur_row_ff :
                       scroll ? ROW_W'(HEIGHT - 1) : row_inc[ROW_W-1:0];

   assign rd_oob = (req_chan.payload.read_row >= ROW_W'(HEIGHT)) ||
                   (req_chan.payload.read_col >= COL_W'(WIDTH));

   // RAM port selection
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cell_addr(phys_row(cur_row_ff, top_ff), cur_col_ff);
      ram_wr_data = {color_ff, req_chan.payload.char_code};
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = {RESET_COLOR, SPACE_CODE};
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_base_ff + ADDR_W'(fill_col_ff);
            ram_wr_data = {color_ff, SPACE_CODE};
         end
         ST_IDLE: begin
            ram_wr_en = req_fire && is_put && !is_newline;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   assign ram_rd_en   = req_fire && !is_put && !rd_oob;
   assign ram_rd_addr = cell_addr(phys_row(req_chan.payload.read_row, top_ff),
                                  req_chan.payload.read_col);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      fill_col_in  = fill_col_ff;
      fill_base_in = fill_base_ff;
      top_in       = top_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      color_in     = csr_write_enable ? csr_write_data : color_ff;
      rd_oob_in    = rd_oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               rsp_data_in.cell_char  = '0;
               rsp_data_in.cell_color = '0;
               if (is_put) begin
                  cur_row_in = next_row;
                  cur_col_in = next_col;
                  rsp_data_in.cursor_row = next_row;
                  rsp_data_in.cursor_col = next_col;
                  rsp_data_in.cursor_pos = linear_pos(next_row, next_col);
                  rsp_data_in.scrolled   = scroll;
                  if (scroll) begin
                     // Rotate the store: the old top row becomes the blank bottom row
                     fill_base_in = cell_addr(top_ff, '0);
                     fill_col_in  = '0;
                     top_in       = (top_ff == ROW_W'(HEIGHT - 1)) ? '0 :
                                    top_ff + ROW_W'(1);
                     state_in     = ST_FILL;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  rd_oob_in = rd_oob;
                  rsp_data_in.cursor_row = cur_row_ff;
                  rsp_data_in.cursor_col = cur_col_ff;
                  rsp_data_in.cursor_pos = linear_pos(cur_row_ff, cur_col_ff);
                  rsp_data_in.scrolled   = 1'b0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rsp_data_in.cell_char  = rd_oob_ff ? '0 : ram_rd_data[CHAR_W-1:0];
            rsp_data_in.cell_color = rd_oob_ff ? '0 : ram_rd_data[CELL_W-1:CHAR_W];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_FILL: begin
            fill_col_in = fill_col_ff + COL_W'(1);
            if (fill_col_ff == COL_W'(WIDTH - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         top_ff       <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         color_ff     <= RESET_COLOR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         top_ff       <= top_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_col_ff  <= fill_col_in;
      fill_base_ff <= fill_base_in;
      rd_oob_ff    <= rd_oob_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `TCP_ASSERT_ALWAYS(a_cursor_range,
      (cur_row_ff < ROW_W'(HEIGHT)) && (cur_col_ff < COL_W'(WIDTH)), "cursor out of screen")
   `TCP_ASSERT_ALWAYS(a_top_range, top_ff < ROW_W'(HEIGHT), "row rotation out of range")
   `TCP_ASSERT_ALWAYS(a_no_overwrite, !(req_fire && rsp_valid_ff && !rsp_chan.ready),
      "transaction taken over an undelivered result")
   `TCP_ASSERT_NEXT(a_scroll_fill, req_fire && is_put && scroll, state_ff == ST_FILL,
      "scroll did not start the row fill")
   `TCP_ASSERT_NEXT(a_read_done, state_ff == ST_READ,
      rsp_valid_ff && (state_ff == ST_IDLE), "read result not presented")
endmodule

// File: sv/tcp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tcp_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: verif/tb_text_console_putchar.sv
// Self-checking testbench for the text console: puts, reads, wraps, scrolls and color changes.
`timescale 1ns / 1ps

module tb_text_console_putchar;
   import tcp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 2 * WIDTH + 20;
   localparam int CHUNK_ITEMS    = 272;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [COLOR_W-1:0] csr_write_data;

   tcp_req_if req_if ();
   tcp_rsp_if rsp_if ();

   text_console_putchar u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if)
   );

   // Shadow of the console: cells are {color, char}.
   logic [CELL_W-1:0]  screen_m [CELL_COUNT];
   int unsigned        row_m;
   int unsigned        col_m;
   logic [COLOR_W-1:0] color_m;

   tcp_req_type console_cmd_q [$];
   tcp_rsp_type console_rsp_q [$];
   tcp_rsp_type want;

   int send_idle_pct;
   int recv_stall_pct;
   int errors;
   int idle_cycles;
   int n_puts, n_newlines, n_wraps, n_scrolls, n_reads, n_outside, n_colors;

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      rsp_if.ready     = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   // Apply one accepted command to the shadow and queue the result it must produce.
   task automatic apply_console_cmd(input tcp_req_type cmd);
      tcp_rsp_type r;
      bit          wrap;
      r = '0;
      if (cmd.operation == OP_READ) begin
         n_reads++;
         if (cmd.read_row < HEIGHT && cmd.read_col < WIDTH)
            {r.cell_color, r.cell_char} = screen_m[cmd.read_row * WIDTH + cmd.read_col];
         else
            n_outside++;
      end else begin
         n_puts++;
         if (cmd.char_code != NEWLINE_CODE) begin
            screen_m[row_m * WIDTH + col_m] = {color_m, cmd.char_code};
            col_m++;
            wrap = (col_m >= WIDTH);
            if (wrap)
               n_wraps++;
         end else begin
            n_newlines++;
            wrap = 1'b1;
         end
         if (wrap) begin
            col_m = 0;
            row_m++;
            if (row_m >= HEIGHT) begin
               row_m = HEIGHT - 1;
               for (int i = 0; i < CELL_COUNT - WIDTH; i++)
                  screen_m[i] = screen_m[i + WIDTH];
               for (int i = CELL_COUNT - WIDTH; i < CELL_COUNT; i++)
                  screen_m[i] = {color_m, SPACE_CODE};
               r.scrolled = 1'b1;
               n_scrolls++;
            end
         end
      end
      r.cursor_row = ROW_W'(row_m);
      r.cursor_col = COL_W'(col_m);
      r.cursor_pos = POS_W'(row_m * WIDTH + col_m);
      console_rsp_q.push_back(r);
   endtask

   function automatic void push_cmd(input logic op, input logic [CHAR_W-1:0] ch,
                                    input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col);
      tcp_req_type c;
      c.operation = op;
      c.char_code = ch;
      c.read_row  = row;
      c.read_col  = col;
      console_cmd_q.push_back(c);
   endfunction

   // Mostly ordinary text with newlines, some long lines that wrap, reads over the screen.
   task automatic queue_random_cmds(input int count);
      int made;
      int run;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 4) begin
            run = $urandom_range(90, 60);
            repeat (run)
               push_cmd(OP_PUT, CHAR_W'($urandom_range(255, 11)), ROW_W'($urandom),
                        COL_W'($urandom));
            made += run;
         end else begin
            if ($urandom_range(99) < 55) begin
               if ($urandom_range(99) < 15)
                  push_cmd(OP_PUT, NEWLINE_CODE, ROW_W'($urandom), COL_W'($urandom));
               else
                  push_cmd(OP_PUT, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            end else if ($urandom_range(99) < 10) begin
               push_cmd(OP_READ, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            end else begin
               push_cmd(OP_READ, CHAR_W'($urandom), ROW_W'($urandom_range(HEIGHT - 1)),
                        COL_W'($urandom_range(WIDTH - 1)));
            end
            made++;
         end
      end
   endtask

   // Hold until every command is accepted and answered, then let the block settle.
   task automatic drain();
      while (console_cmd_q.size() != 0 || req_if.valid || console_rsp_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_color(input logic [COLOR_W-1:0] c);
      drain();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      n_colors++;
   endtask

   // Driver: predict on acceptance, then present the next command or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (csr_write_enable)
            color_m = csr_write_data;
         if (req_if.valid && req_if.ready)
            apply_console_cmd(req_if.payload);
         if (!req_if.valid || req_if.ready) begin
            if (console_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= console_cmd_q.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transaction with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (console_rsp_q.size() == 0) begin
               $error("result transaction with no command outstanding");
               errors++;
            end else begin
               want = console_rsp_q.pop_front();
               check_field("cell_char", want.cell_char, rsp_if.payload.cell_char);
               check_field("cell_color", want.cell_color, rsp_if.payload.cell_color);
               check_field("cursor_row", want.cursor_row, rsp_if.payload.cursor_row);
               check_field("cursor_col", want.cursor_col, rsp_if.payload.cursor_col);
               check_field("cursor_pos", want.cursor_pos, rsp_if.payload.cursor_pos);
               check_field("scrolled", want.scrolled, rsp_if.payload.scrolled);
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      errors         = 0;
      idle_cycles    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      n_puts = 0; n_newlines = 0; n_wraps = 0; n_scrolls = 0;
      n_reads = 0; n_outside = 0; n_colors = 0;
      row_m   = 0;
      col_m   = 0;
      color_m = RESET_COLOR;
      for (int i = 0; i < CELL_COUNT; i++)
         screen_m[i] = {RESET_COLOR, SPACE_CODE};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: cleared screen, screen corners, reads off the screen, byte extremes.
      push_cmd(OP_READ, 8'h00, 5'd0, 7'd0);
      push_cmd(OP_READ, 8'hFF, ROW_W'(HEIGHT - 1), COL_W'(WIDTH - 1));
      push_cmd(OP_READ, 8'h00, ROW_W'(HEIGHT), 7'd0);
      push_cmd(OP_READ, 8'h00, 5'd0, COL_W'(WIDTH));
      push_cmd(OP_READ, 8'hFF, 5'd31, 7'd127);
      push_cmd(OP_PUT, 8'h00, 5'd31, 7'd127);
      push_cmd(OP_PUT, 8'hFF, 5'd0, 7'd0);
      push_cmd(OP_PUT, 8'h41, 5'd0, 7'd0);
      push_cmd(OP_PUT, 8'h0B, 5'd0, 7'd0);
      push_cmd(OP_PUT, NEWLINE_CODE, 5'd31, 7'd127);
      push_cmd(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0);
      push_cmd(OP_PUT, 8'h09, 5'd0, 7'd0);
      push_cmd(OP_PUT, SPACE_CODE, 5'd0, 7'd0);
      push_cmd(OP_READ, 8'h00, 5'd0, 7'd0);
      push_cmd(OP_READ, 8'h00, 5'd0, 7'd1);
      push_cmd(OP_READ, 8'h00, 5'd0, 7'd2);
      push_cmd(OP_READ, 8'h00, 5'd0, 7'd3);
      push_cmd(OP_READ, 8'h00, 5'd0, 7'd4);
      push_cmd(OP_READ, 8'h00, 5'd2, 7'd0);
      push_cmd(OP_READ, 8'h00, 5'd2, 7'd1);
      drain();

      for (int k = 0; k < 6; k++) begin
         case (k)
            0: set_color(8'hFF);
            1: set_color(8'h00);
            default: set_color(COLOR_W'($urandom));
         endcase
         if (k < 2) begin
            send_idle_pct  = 20;
            recv_stall_pct = 49;
         end else if (k < 4) begin
            send_idle_pct  = 49;
            recv_stall_pct = 20;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         queue_random_cmds(CHUNK_ITEMS);
      end
      drain();

      $display("Covered %0d puts (%0d newlines, %0d line wraps, %0d scrolls) and %0d reads",
               n_puts, n_newlines, n_wraps, n_scrolls, n_reads);
      $display("(%0d outside the screen) under %0d text colors after the reset one.",
               n_outside, n_colors);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
